FILE: src/crast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crast_pkg: shared types and constants of the circle raster canvas
// Canvas geometry, field widths, op and status codes, the command that
// travels from the front end to the back end, and the configuration bundle.
// ----------------------------------------------------------------------------
package crast_pkg;

    // canvas geometry; the address is {row, col}, so sizes are powers of two
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;

    // field widths
    localparam int CFG_SIZE_W = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int BG_W       = 7;
    localparam int CHAR_W     = 8;
    localparam int COORD_W    = 20;
    localparam int RD_COL_W   = 9;
    localparam int RD_ROW_W   = 9;
    localparam int Q_FRAC     = 8;

    // radius magnitude and its square (positive radius only)
    localparam int RMAG_W = COORD_W - 1;
    localparam int RSQ_W  = 2 * RMAG_W;

    // cell offset from the centre, Q.8, and its square in Q.16
    localparam int POS_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + Q_FRAC;
    localparam int DX_W  = ((POS_W > COORD_W - 1) ? POS_W : COORD_W - 1) + 2;
    localparam int SQ_W  = 2 * DX_W;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // op codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_RADIUS = 2'd1;
    localparam logic [1:0] STS_CHAR   = 2'd2;
    localparam logic [1:0] STS_RANGE  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

    // printable range and register reset values
    localparam logic [CHAR_W-1:0]     PRINT_LO  = 8'd32;
    localparam logic [CHAR_W-1:0]     PRINT_HI  = 8'd126;
    localparam logic [BG_W-1:0]       BG_LO     = 7'd32;
    localparam logic [BG_W-1:0]       BG_HI     = 7'd126;
    localparam logic [CFG_SIZE_W-1:0] SIZE_RST  = 10'd1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_REPORT = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [CFG_SIZE_W-1:0] width;
        logic [CFG_SIZE_W-1:0] height;
        logic [BG_W-1:0]       bg;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [1:0]                  status;
        logic                        use_inner;
        logic [CHAR_W-1:0]           paint_char;
        logic signed [COORD_W-1:0]   cx;
        logic signed [COORD_W-1:0]   cy;
        logic [RSQ_W-1:0]            outer;
        logic [RSQ_W-1:0]            inner;
        logic [COL_W-1:0]            col;
        logic [ROW_W-1:0]            row;
    } cmd_t;

endpackage

FILE: src/crast_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crast_front: input stage and classifier
// Holds one input transaction, checks it, squares the radii and hands a
// ready-to-run command to the queue.
// ----------------------------------------------------------------------------
module crast_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         op,
    input  logic signed [crast_pkg::COORD_W-1:0] center_x,
    input  logic signed [crast_pkg::COORD_W-1:0] center_y,
    input  logic signed [crast_pkg::COORD_W-1:0] radius,
    input  logic                               filled,
    input  logic [crast_pkg::CHAR_W-1:0]       paint_char,
    input  logic [crast_pkg::RD_COL_W-1:0]     cell_col,
    input  logic [crast_pkg::RD_ROW_W-1:0]     cell_row,
    input  crast_pkg::cfg_t                    cfg,
    input  logic                               q_full,
    output logic                               q_push,
    output crast_pkg::cmd_t                    q_wdata
);

    logic                                   hold_valid_reg;
    logic                                   hold_valid_next;
    logic [1:0]                             op_reg;
    logic signed [crast_pkg::COORD_W-1:0]   cx_reg;
    logic signed [crast_pkg::COORD_W-1:0]   cy_reg;
    logic signed [crast_pkg::COORD_W-1:0]   radius_reg;
    logic                                   filled_reg;
    logic [crast_pkg::CHAR_W-1:0]           paint_reg;
    logic [crast_pkg::RD_COL_W-1:0]         col_reg;
    logic [crast_pkg::RD_ROW_W-1:0]         row_reg;

    logic                                   accept;
    logic signed [crast_pkg::COORD_W-1:0]   inner_r;
    logic [crast_pkg::RMAG_W-1:0]           r_mag;
    logic [crast_pkg::RMAG_W-1:0]           ir_mag;
    logic                                   has_inner;
    logic                                   printable;

    assign q_push   = hold_valid_reg && !q_full;
    assign in_stall = hold_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            cx_reg     <= center_x;
            cy_reg     <= center_y;
            radius_reg <= radius;
            filled_reg <= filled;
            paint_reg  <= paint_char;
            col_reg    <= cell_col;
            row_reg    <= cell_row;
        end
    end

    // squares are taken as magnitudes; only used when the radius is positive
    assign inner_r   = radius_reg - crast_pkg::COORD_W'(1 << crast_pkg::Q_FRAC);
    assign has_inner = inner_r > $signed(crast_pkg::COORD_W'(0));
    assign r_mag     = radius_reg[crast_pkg::RMAG_W-1:0];
    assign ir_mag    = inner_r[crast_pkg::RMAG_W-1:0];
    assign printable = (paint_reg >= crast_pkg::PRINT_LO) && (paint_reg <= crast_pkg::PRINT_HI);

    always_comb
    begin
        q_wdata.kind       = crast_pkg::CMD_REPORT;
        q_wdata.status     = crast_pkg::STS_OK;
        q_wdata.use_inner  = !filled_reg && has_inner;
        q_wdata.paint_char = paint_reg;
        q_wdata.cx         = cx_reg;
        q_wdata.cy         = cy_reg;
        q_wdata.outer      = crast_pkg::RSQ_W'(r_mag) * crast_pkg::RSQ_W'(r_mag);
        q_wdata.inner      = crast_pkg::RSQ_W'(ir_mag) * crast_pkg::RSQ_W'(ir_mag);
        q_wdata.col        = crast_pkg::COL_W'(col_reg);
        q_wdata.row        = crast_pkg::ROW_W'(row_reg);

        priority if (op_reg == crast_pkg::OP_CLEAR)
        begin
            q_wdata.kind = crast_pkg::CMD_CLEAR;
        end
        else if (op_reg == crast_pkg::OP_DRAW)
        begin
            priority if (radius_reg <= $signed(crast_pkg::COORD_W'(0)))
            begin
                q_wdata.status = crast_pkg::STS_RADIUS;
            end
            else if (!printable)
            begin
                q_wdata.status = crast_pkg::STS_CHAR;
            end
            else
            begin
                q_wdata.kind = crast_pkg::CMD_DRAW;
            end
        end
        else if (op_reg == crast_pkg::OP_READ)
        begin
            if ((crast_pkg::CFG_SIZE_W'(col_reg) >= cfg.width) ||
                (crast_pkg::CFG_SIZE_W'(row_reg) >= cfg.height))
            begin
                q_wdata.status = crast_pkg::STS_RANGE;
            end
            else
            begin
                q_wdata.kind = crast_pkg::CMD_READ;
            end
        end
        else
        begin
            q_wdata.kind = crast_pkg::CMD_REPORT;
        end
    end

endmodule

FILE: src/crast_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crast_queue: command queue
// Small register FIFO between the classifier and the sweep engine.
// ----------------------------------------------------------------------------
module crast_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  crast_pkg::cmd_t wdata,
    input  logic            pop,
    output crast_pkg::cmd_t rdata,
    output logic            full,
    output logic            not_empty
);

    crast_pkg::cmd_t                  slots [crast_pkg::Q_DEPTH];
    logic [crast_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [crast_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [crast_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [crast_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [crast_pkg::Q_CNT_W-1:0]    count_reg;
    logic [crast_pkg::Q_CNT_W-1:0]    count_next;
    logic                             do_push;
    logic                             do_pop;

    localparam logic [crast_pkg::Q_PTR_W-1:0] PTR_LAST = crast_pkg::Q_PTR_W'(crast_pkg::Q_DEPTH - 1);

    assign full      = count_reg == crast_pkg::Q_CNT_W'(crast_pkg::Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: src/crast_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crast_back: sweep engine, canvas memory and result register
// Runs clears and draws one cell per cycle through a three-stage distance
// pipe, serves reads from the canvas and holds the result transaction.
// ----------------------------------------------------------------------------
module crast_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  crast_pkg::cfg_t              cfg,
    input  logic                         q_valid,
    input  crast_pkg::cmd_t              q_data,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [crast_pkg::CHAR_W-1:0] cell_char
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_READ  = 4'b1000
    } back_state_t;

    back_state_t                       state_reg;
    back_state_t                       state_next;
    crast_pkg::cmd_t                   cmd_reg;
    crast_pkg::cmd_t                   cmd_next;
    logic [crast_pkg::COL_W-1:0]       col_reg;
    logic [crast_pkg::COL_W-1:0]       col_next;
    logic [crast_pkg::ROW_W-1:0]       row_reg;
    logic [crast_pkg::ROW_W-1:0]       row_next;

    // distance pipe
    logic                              p1_valid_reg;
    logic [crast_pkg::ADDR_W-1:0]      p1_addr_reg;
    logic [crast_pkg::SQ_W-1:0]        p1_sqx_reg;
    logic [crast_pkg::SQ_W-1:0]        p1_sqy_reg;
    logic                              p2_valid_reg;
    logic [crast_pkg::ADDR_W-1:0]      p2_addr_reg;
    logic [crast_pkg::SQ_W-1:0]        p2_d2_reg;

    // result register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [1:0]                        status_reg;
    logic [crast_pkg::CHAR_W-1:0]      char_reg;

    logic [crast_pkg::CHAR_W-1:0]      canvas_mem [crast_pkg::CELL_COUNT];
    logic [crast_pkg::CHAR_W-1:0]      rdata_reg;

    logic                              slot_free;
    logic                              issue;
    logic                              mem_re;
    logic                              load;
    logic [1:0]                        res_status;
    logic [crast_pkg::CHAR_W-1:0]      res_char;
    logic                              last_col;
    logic                              last_row;
    logic signed [crast_pkg::DX_W-1:0] dx;
    logic signed [crast_pkg::DX_W-1:0] dy;
    logic signed [crast_pkg::SQ_W-1:0] sqx;
    logic signed [crast_pkg::SQ_W-1:0] sqy;
    logic                              in_outer;
    logic                              in_hole;
    logic                              wr_en;
    logic [crast_pkg::CHAR_W-1:0]      wr_char;

    assign slot_free = !out_valid_reg || !out_stall;
    assign last_col  = crast_pkg::CFG_SIZE_W'(col_reg) == cfg.width - 1'b1;
    assign last_row  = crast_pkg::CFG_SIZE_W'(row_reg) == cfg.height - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        q_pop      = 1'b0;
        issue      = 1'b0;
        mem_re     = 1'b0;
        load       = 1'b0;
        res_status = crast_pkg::STS_OK;
        res_char   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    col_next = '0;
                    row_next = '0;
                    unique case (q_data.kind)
                        crast_pkg::CMD_CLEAR,
                        crast_pkg::CMD_DRAW:
                        begin
                            state_next = ST_SWEEP;
                        end
                        crast_pkg::CMD_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            load       = 1'b1;
                            res_status = q_data.status;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                issue = 1'b1;
                if (last_col)
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                load       = 1'b1;
                res_char   = rdata_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // stage 0: offsets from the centre in Q.8, squared into stage 1
    assign dx  = crast_pkg::DX_W'(signed'({1'b0, col_reg, crast_pkg::Q_FRAC'(0)}))
                 - crast_pkg::DX_W'(cmd_reg.cx);
    assign dy  = crast_pkg::DX_W'(signed'({1'b0, row_reg, crast_pkg::Q_FRAC'(0)}))
                 - crast_pkg::DX_W'(cmd_reg.cy);
    assign sqx = crast_pkg::SQ_W'(dx) * crast_pkg::SQ_W'(dx);
    assign sqy = crast_pkg::SQ_W'(dy) * crast_pkg::SQ_W'(dy);

    // stage 3: ring test and write
    assign in_outer = p2_d2_reg <= crast_pkg::SQ_W'(cmd_reg.outer);
    assign in_hole  = cmd_reg.use_inner && (p2_d2_reg < crast_pkg::SQ_W'(cmd_reg.inner));
    assign wr_en    = p2_valid_reg &&
                      ((cmd_reg.kind == crast_pkg::CMD_CLEAR) || (in_outer && !in_hole));
    assign wr_char  = (cmd_reg.kind == crast_pkg::CMD_CLEAR) ?
                      crast_pkg::CHAR_W'(cfg.bg) : cmd_reg.paint_char;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= issue;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        p1_addr_reg <= {row_reg, col_reg};
        p1_sqx_reg  <= unsigned'(sqx);
        p1_sqy_reg  <= unsigned'(sqy);
        p2_addr_reg <= p1_addr_reg;
        p2_d2_reg   <= p1_sqx_reg + p1_sqy_reg;
        if (load)
        begin
            status_reg <= res_status;
            char_reg   <= res_char;
        end
    end

    // canvas: one write port from the pipe, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            canvas_mem[p2_addr_reg] <= wr_char;
        end
        if (mem_re)
        begin
            rdata_reg <= canvas_mem[{q_data.row, q_data.col}];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign cell_char = char_reg;

endmodule

FILE: src/circle_raster_canvas.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_raster_canvas: character canvas with filled and outline circles
// Clears the canvas, draws circles by exact squared-distance test in Q.16
// and reads single cells. One result transaction per input transaction.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid / in_stall    | op, center_x, center_y, radius,
//           |                        | filled, paint_char, cell_col, cell_row
//  output   | out_valid / out_stall  | status, cell_char
//  config   | cfg_we (no wait)       | cfg_index, cfg_data
//
//  Clear and draw: the sweep engine visits all width * height cells (one
//  canvas cell per cycle, one memory write port), then drains the distance
//  pipe. Reads use the canvas read port; rejected items skip the sweep.
//  Reset clears control state only; canvas contents are undefined until the
//  first clear, and there is no clearing pass.
//  Input and output stall independently: the two-entry command queue and
//  the result register decouple the classifier from the sweep engine.
// ----------------------------------------------------------------------------
module circle_raster_canvas (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             op,
    input  logic signed [crast_pkg::COORD_W-1:0]   center_x,
    input  logic signed [crast_pkg::COORD_W-1:0]   center_y,
    input  logic signed [crast_pkg::COORD_W-1:0]   radius,
    input  logic                                   filled,
    input  logic [crast_pkg::CHAR_W-1:0]           paint_char,
    input  logic [crast_pkg::RD_COL_W-1:0]         cell_col,
    input  logic [crast_pkg::RD_ROW_W-1:0]         cell_row,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [1:0]                             status,
    output logic [crast_pkg::CHAR_W-1:0]           cell_char,

    input  logic                                   cfg_we,
    input  logic [crast_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [crast_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // configuration registers, held in range on write
    logic [crast_pkg::CFG_SIZE_W-1:0] width_reg;
    logic [crast_pkg::CFG_SIZE_W-1:0] width_next;
    logic [crast_pkg::CFG_SIZE_W-1:0] height_reg;
    logic [crast_pkg::CFG_SIZE_W-1:0] height_next;
    logic [crast_pkg::BG_W-1:0]       bg_reg;
    logic [crast_pkg::BG_W-1:0]       bg_next;
    logic [crast_pkg::CFG_SIZE_W-1:0] size_in;
    logic [crast_pkg::BG_W-1:0]       bg_in;
    crast_pkg::cfg_t                  cfg;

    // front to queue to back
    logic                             q_push;
    logic                             q_pop;
    logic                             q_full;
    logic                             q_valid;
    crast_pkg::cmd_t                  q_wdata;
    crast_pkg::cmd_t                  q_rdata;

    assign size_in = crast_pkg::CFG_SIZE_W'(cfg_data);
    assign bg_in   = crast_pkg::BG_W'(cfg_data);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        bg_next     = bg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                crast_pkg::REG_WIDTH:
                begin
                    priority if (size_in == '0)
                        width_next = crast_pkg::SIZE_RST;
                    else if (32'(size_in) > crast_pkg::MAX_WIDTH)
                        width_next = crast_pkg::CFG_SIZE_W'(crast_pkg::MAX_WIDTH);
                    else
                        width_next = size_in;
                end
                crast_pkg::REG_HEIGHT:
                begin
                    priority if (size_in == '0)
                        height_next = crast_pkg::SIZE_RST;
                    else if (32'(size_in) > crast_pkg::MAX_HEIGHT)
                        height_next = crast_pkg::CFG_SIZE_W'(crast_pkg::MAX_HEIGHT);
                    else
                        height_next = size_in;
                end
                crast_pkg::REG_BG:
                begin
                    // below space goes to space, DEL goes to tilde
                    priority if (bg_in < crast_pkg::BG_LO)
                        bg_next = crast_pkg::BG_LO;
                    else if (bg_in > crast_pkg::BG_HI)
                        bg_next = crast_pkg::BG_HI;
                    else
                        bg_next = bg_in;
                end
                default:
                begin
                    // unmapped index: write is ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= crast_pkg::SIZE_RST;
            height_reg <= crast_pkg::SIZE_RST;
            bg_reg     <= crast_pkg::BG_LO;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            bg_reg     <= bg_next;
        end
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.bg     = bg_reg;

    // classifier: checks the transaction and squares the radii
    crast_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .filled     (filled),
        .paint_char (paint_char),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .cfg        (cfg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    crast_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .full      (q_full),
        .not_empty (q_valid)
    );

    // sweep engine, canvas memory and result register
    crast_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cell_char (cell_char)
    );

    // input only backs up when the queue is full
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full)
        else $error("input stalled with room in the queue");

    // the classifier never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full command queue");

    // a command is only taken when the result register can accept its result
    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && (!out_valid || !out_stall)))
        else $error("command popped while result register blocked");

    // canvas size stays within its legal range
    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (width_reg != '0 && height_reg != '0 &&
                  32'(width_reg) <= crast_pkg::MAX_WIDTH &&
                  32'(height_reg) <= crast_pkg::MAX_HEIGHT))
        else $error("canvas size register out of range");

endmodule
